>>> design/hrss_pkg.sv
// ----------------------------------------------------------------------------
// hrss_pkg: shared types for the hash ring server select block
// Operation and status codes, search modes of the ring cells, sequencer
// states and the control word broadcast to every cell.
// ----------------------------------------------------------------------------
package hrss_pkg;

  localparam int POINT_W = 32;

  typedef enum logic [1:0] {
    OP_CLEAR        = 2'd0,
    OP_INSERT       = 2'd1,
    OP_LOOKUP_KEY   = 2'd2,
    OP_LOOKUP_AFTER = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_READY = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Search mode of the cells: locate a server's first point, key lookup,
  // lookup past a located server.
  typedef enum logic [1:0] {
    Q_MATCH = 2'd0,
    Q_KEY   = 2'd1,
    Q_AFTER = 2'd2
  } qmode_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_EXEC  = 3'd1,
    S_GRP   = 3'd2,
    S_SEL   = 3'd3,
    S_DONE  = 3'd4,
    S_AFTER = 3'd5
  } state_t;

  typedef struct packed {
    logic   clr;
    logic   ins;
    logic   eval;
    qmode_t mode;
  } cell_ctl_t;

endpackage

>>> design/hrss_cell.sv
// ----------------------------------------------------------------------------
// hrss_cell: one slot of the sorted ring
// Holds one point and its owner. On insert it keeps its point, takes the new
// point, or takes its left neighbor's point, so the row stays sorted. On a
// search it registers its primary and fallback candidate flags.
// ----------------------------------------------------------------------------
module hrss_cell #(
  parameter int IDX          = 0,
  parameter int IDX_W        = 8,
  parameter int SID_W        = 4,
  parameter int SERVER_COUNT = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hrss_pkg::cell_ctl_t        ctl,
  input  logic [hrss_pkg::POINT_W-1:0] value,
  input  logic [hrss_pkg::POINT_W-1:0] hash,
  input  logic [SID_W-1:0]           sid,
  input  logic [SERVER_COUNT-1:0]    mask,
  input  logic [IDX_W-1:0]           found,
  input  logic [hrss_pkg::POINT_W-1:0] left_point,
  input  logic [SID_W-1:0]           left_owner,
  input  logic                       left_valid,
  input  logic                       left_below,
  output logic [hrss_pkg::POINT_W-1:0] point,
  output logic [SID_W-1:0]           owner,
  output logic                       valid,
  output logic                       below,
  output logic                       prim,
  output logic                       fb
);
  import hrss_pkg::*;

  logic [POINT_W-1:0] point_r;
  logic [SID_W-1:0]   owner_r;
  logic               valid_r;
  logic               valid_nxt;
  logic               prim_r;
  logic               prim_nxt;
  logic               fb_r;
  logic               fb_nxt;
  logic               ready;
  logic               is_sid;

  assign point = point_r;
  assign owner = owner_r;
  assign valid = valid_r;
  assign prim  = prim_r;
  assign fb    = fb_r;

  always_comb begin
    // equal points stay ahead of the new one
    below     = valid_r && (point_r <= value);
    valid_nxt = below || left_below || left_valid;
    ready     = |(mask & (SERVER_COUNT'(1) << owner_r));
    is_sid    = (owner_r == sid);
    prim_nxt  = 1'b0;
    fb_nxt    = 1'b0;
    case (ctl.mode)
      Q_MATCH: begin
        prim_nxt = valid_r && is_sid;
      end
      Q_KEY: begin
        fb_nxt   = valid_r && ready;
        prim_nxt = valid_r && ready && (point_r >= hash);
      end
      Q_AFTER: begin
        fb_nxt   = valid_r && ready && !is_sid;
        prim_nxt = valid_r && ready && !is_sid && (IDX_W'(IDX) > found);
      end
      default: begin
        prim_nxt = 1'b0;
        fb_nxt   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clr) begin
      valid_r <= 1'b0;
    end else if (ctl.ins) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && !below) begin
      // shift right behind the insert position, take the new word at it
      point_r <= left_below ? value : left_point;
      owner_r <= left_below ? sid : left_owner;
    end
    if (ctl.eval) begin
      prim_r <= prim_nxt;
      fb_r   <= fb_nxt;
    end
  end

endmodule

>>> design/hrss_find.sv
// ----------------------------------------------------------------------------
// hrss_find: two-stage first-set finder over the cell flags
// Stage one finds the first primary and first fallback flag in each group of
// cells, stage two picks the first group. Primary hits win over fallback.
// Returns the hit, its cell index and the owner carried with it.
// ----------------------------------------------------------------------------
module hrss_find #(
  parameter int N     = 256,
  parameter int IDX_W = 8,
  parameter int PW    = 4
) (
  input  logic                clk,
  input  logic [N-1:0]        prim,
  input  logic [N-1:0]        fb,
  input  logic [N-1:0][PW-1:0] pay,
  output logic                hit,
  output logic [IDX_W-1:0]    idx,
  output logic [PW-1:0]       pay_out
);
  localparam int GRP_W  = (IDX_W + 1) / 2;
  localparam int NGRP_W = IDX_W - GRP_W;
  localparam int GRP    = 1 << GRP_W;
  localparam int NGRP   = 1 << NGRP_W;
  localparam int FULL   = 1 << IDX_W;

  logic [FULL-1:0]          prim_pad;
  logic [FULL-1:0]          fb_pad;
  logic [FULL-1:0][PW-1:0]  pay_pad;

  logic [NGRP-1:0]             p_any_nxt, p_any_r, f_any_nxt, f_any_r;
  logic [NGRP-1:0][GRP_W-1:0]  p_off_nxt, p_off_r, f_off_nxt, f_off_r;
  logic [NGRP-1:0][PW-1:0]     p_pay_nxt, p_pay_r, f_pay_nxt, f_pay_r;

  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [PW-1:0]     pay_r, pay_nxt;

  assign prim_pad = FULL'(prim);
  assign fb_pad   = FULL'(fb);
  assign pay_pad  = (FULL * PW)'(pay);

  assign hit     = hit_r;
  assign idx     = idx_r;
  assign pay_out = pay_r;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      p_any_nxt[g] = 1'b0;
      p_off_nxt[g] = '0;
      p_pay_nxt[g] = '0;
      f_any_nxt[g] = 1'b0;
      f_off_nxt[g] = '0;
      f_pay_nxt[g] = '0;
      // scan down so the lowest set bit wins
      for (int j = GRP - 1; j >= 0; j--) begin
        if (prim_pad[g*GRP + j]) begin
          p_any_nxt[g] = 1'b1;
          p_off_nxt[g] = GRP_W'(j);
          p_pay_nxt[g] = pay_pad[g*GRP + j];
        end
        if (fb_pad[g*GRP + j]) begin
          f_any_nxt[g] = 1'b1;
          f_off_nxt[g] = GRP_W'(j);
          f_pay_nxt[g] = pay_pad[g*GRP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p_any_r <= p_any_nxt;
    p_off_r <= p_off_nxt;
    p_pay_r <= p_pay_nxt;
    f_any_r <= f_any_nxt;
    f_off_r <= f_off_nxt;
    f_pay_r <= f_pay_nxt;
  end

  always_comb begin
    logic [IDX_W-1:0] p_idx, f_idx;
    logic [PW-1:0]    p_pay, f_pay;
    p_idx = '0;
    f_idx = '0;
    p_pay = '0;
    f_pay = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (p_any_r[g]) begin
        p_idx = IDX_W'((g << GRP_W) + int'(p_off_r[g]));
        p_pay = p_pay_r[g];
      end
      if (f_any_r[g]) begin
        f_idx = IDX_W'((g << GRP_W) + int'(f_off_r[g]));
        f_pay = f_pay_r[g];
      end
    end
    hit_nxt = (|p_any_r) || (|f_any_r);
    idx_nxt = (|p_any_r) ? p_idx : f_idx;
    pay_nxt = (|p_any_r) ? p_pay : f_pay;
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    idx_r <= idx_nxt;
    pay_r <= pay_nxt;
  end

endmodule

>>> design/hash_ring_server_select_core.sv
// ----------------------------------------------------------------------------
// hash_ring_server_select_core: consistent-hash ring server selector
// Keeps a sorted ring of points in a row of cells and picks the first ready
// server owning a point at or past a key hash, or past a given server.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with in_op and its operands while busy is low; the word is
//   taken at that edge and busy rises in the next cycle. Exactly one result
//   word follows, shown for one cycle with out_strobe high. The receiver
//   cannot stall; out_ring_count holds the ring size after the latest item.
// Clear, insert and a lookup on an empty ring act on the cell row in the
// execute state, which also registers the result. A lookup by key hash runs
// one search pass (flag capture in the cells, two finder stages, decision),
// then the result. A lookup after server runs a locating pass before that
// search. A new word can be accepted in the cycle its predecessor's result
// is strobed.
// Reset empties the ring at once; point and owner contents are not cleared,
// only the per-cell valid bits and the point count.
// ----------------------------------------------------------------------------
module hash_ring_server_select_core #(
  parameter int RING_DEPTH   = 256,
  parameter int SERVER_COUNT = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_op,
  input  logic [hrss_pkg::POINT_W-1:0]        in_ring_point_value,
  input  logic [$clog2(SERVER_COUNT)-1:0]     in_server_id,
  input  logic [hrss_pkg::POINT_W-1:0]        in_key_hash,
  input  logic [SERVER_COUNT-1:0]             in_idle_mask,
  output logic                                out_strobe,
  output logic [1:0]                          out_status,
  output logic [$clog2(SERVER_COUNT)-1:0]     out_selected_server,
  output logic [$clog2(RING_DEPTH+1)-1:0]     out_ring_count
);
  import hrss_pkg::*;

  localparam int SID_W = $clog2(SERVER_COUNT);
  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  state_t             state_r, state_nxt;
  qmode_t             qmode_r, qmode_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   found_r, found_nxt;
  logic               strobe_r, strobe_nxt;
  status_t            status_r, status_nxt;
  logic [SID_W-1:0]   sel_r, sel_nxt;
  cell_ctl_t          ctl;

  op_t                op_r;
  logic [POINT_W-1:0] value_r;
  logic [POINT_W-1:0] hash_r;
  logic [SID_W-1:0]   sid_r;
  logic [SERVER_COUNT-1:0] mask_r;

  logic [RING_DEPTH-1:0][POINT_W-1:0] point_w;
  logic [RING_DEPTH-1:0][SID_W-1:0]   owner_w;
  logic [RING_DEPTH-1:0]              valid_w;
  logic [RING_DEPTH-1:0]              below_w;
  logic [RING_DEPTH-1:0]              prim_w;
  logic [RING_DEPTH-1:0]              fb_w;

  logic              fnd_hit;
  logic [IDX_W-1:0]  fnd_idx;
  logic [SID_W-1:0]  fnd_pay;

  assign busy                = (state_r != S_IDLE);
  assign out_strobe          = strobe_r;
  assign out_status          = status_r;
  assign out_selected_server = sel_r;
  assign out_ring_count      = count_r;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r    <= op_t'(in_op);
      value_r <= in_ring_point_value;
      hash_r  <= in_key_hash;
      sid_r   <= in_server_id;
      mask_r  <= in_idle_mask;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < RING_DEPTH; gi++) begin : g_cell
      logic [POINT_W-1:0] lp;
      logic [SID_W-1:0]   lo;
      logic               lv;
      logic               lb;
      if (gi == 0) begin : g_head
        // the head takes the new word whenever its own point is not below it
        assign lp = '0;
        assign lo = '0;
        assign lv = 1'b0;
        assign lb = 1'b1;
      end else begin : g_body
        assign lp = point_w[gi-1];
        assign lo = owner_w[gi-1];
        assign lv = valid_w[gi-1];
        assign lb = below_w[gi-1];
      end
      hrss_cell #(
        .IDX          (gi),
        .IDX_W        (IDX_W),
        .SID_W        (SID_W),
        .SERVER_COUNT (SERVER_COUNT)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .value      (value_r),
        .hash       (hash_r),
        .sid        (sid_r),
        .mask       (mask_r),
        .found      (found_r),
        .left_point (lp),
        .left_owner (lo),
        .left_valid (lv),
        .left_below (lb),
        .point      (point_w[gi]),
        .owner      (owner_w[gi]),
        .valid      (valid_w[gi]),
        .below      (below_w[gi]),
        .prim       (prim_w[gi]),
        .fb         (fb_w[gi])
      );
    end
  endgenerate

  hrss_find #(
    .N     (RING_DEPTH),
    .IDX_W (IDX_W),
    .PW    (SID_W)
  ) u_find (
    .clk     (clk),
    .prim    (prim_w),
    .fb      (fb_w),
    .pay     (owner_w),
    .hit     (fnd_hit),
    .idx     (fnd_idx),
    .pay_out (fnd_pay)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      qmode_r  <= Q_KEY;
      count_r  <= '0;
      found_r  <= '0;
      strobe_r <= 1'b0;
      status_r <= ST_OK;
      sel_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      qmode_r  <= qmode_nxt;
      count_r  <= count_nxt;
      found_r  <= found_nxt;
      strobe_r <= strobe_nxt;
      status_r <= status_nxt;
      sel_r    <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    qmode_nxt  = qmode_r;
    count_nxt  = count_r;
    found_nxt  = found_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    sel_nxt    = sel_r;
    ctl        = '{clr: 1'b0, ins: 1'b0, eval: 1'b0, mode: Q_KEY};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        status_nxt = ST_OK;
        sel_nxt    = '0;
        case (op_r)
          OP_CLEAR: begin
            ctl.clr   = 1'b1;
            count_nxt = '0;
          end
          OP_INSERT: begin
            if (count_r == CNT_W'(RING_DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              ctl.ins   = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          default: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              // first pass: key search, or locate the server to skip
              strobe_nxt = 1'b0;
              ctl.eval   = 1'b1;
              ctl.mode   = (op_r == OP_LOOKUP_KEY) ? Q_KEY : Q_MATCH;
              qmode_nxt  = ctl.mode;
              state_nxt  = S_GRP;
            end
          end
        endcase
      end
      S_AFTER: begin
        ctl.eval  = 1'b1;
        ctl.mode  = Q_AFTER;
        qmode_nxt = Q_AFTER;
        state_nxt = S_GRP;
      end
      S_GRP: begin
        state_nxt = S_SEL;
      end
      S_SEL: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (qmode_r == Q_MATCH) begin
          // absent server starts the walk at index one
          found_nxt = fnd_hit ? fnd_idx : '0;
          state_nxt = S_AFTER;
        end else begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          status_nxt = fnd_hit ? ST_OK : ST_NO_READY;
          sel_nxt    = fnd_hit ? fnd_pay : '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/hrss_chk.sv
// ----------------------------------------------------------------------------
// hrss_chk: port-level checks for the hash ring server select block
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module hrss_chk #(
  parameter int RING_DEPTH   = 256,
  parameter int SERVER_COUNT = 16
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_strobe,
  input logic [1:0]                      out_status,
  input logic [$clog2(SERVER_COUNT)-1:0] out_selected_server,
  input logic [$clog2(RING_DEPTH+1)-1:0] out_ring_count
);
  import hrss_pkg::*;

  // a taken word keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_fail_no_server: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != ST_OK) |-> (out_selected_server == '0))
    else $error("server reported with a failing status");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == ST_FULL) |-> (out_ring_count == RING_DEPTH))
    else $error("ring full reported below depth");

  a_count_moves_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ring_count != $past(out_ring_count)) |-> out_strobe)
    else $error("ring count changed without a result");

endmodule

bind hash_ring_server_select_core hrss_chk #(
  .RING_DEPTH   (RING_DEPTH),
  .SERVER_COUNT (SERVER_COUNT)
) u_hrss_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_strobe          (out_strobe),
  .out_status          (out_status),
  .out_selected_server (out_selected_server),
  .out_ring_count      (out_ring_count)
);

>>> tb/sv/hash_ring_server_select_checker.sv
// ----------------------------------------------------------------------------
// hash_ring_server_select_checker: scoreboard for the hash ring selector
// Watches the command and result channels, keeps its own sorted copy of the
// ring, predicts the reply to every accepted word and compares each strobed
// result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module hash_ring_server_select_checker #(
  parameter int RING_DEPTH   = 256,
  parameter int SERVER_COUNT = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [1:0]                          in_op,
  input  logic [hrss_pkg::POINT_W-1:0]        in_ring_point_value,
  input  logic [$clog2(SERVER_COUNT)-1:0]     in_server_id,
  input  logic [hrss_pkg::POINT_W-1:0]        in_key_hash,
  input  logic [SERVER_COUNT-1:0]             in_idle_mask,
  input  logic                                out_strobe,
  input  logic [1:0]                          out_status,
  input  logic [$clog2(SERVER_COUNT)-1:0]     out_selected_server,
  input  logic [$clog2(RING_DEPTH+1)-1:0]     out_ring_count,
  output int                                  mismatch_count,
  output int                                  words_pending,
  output int                                  results_checked
);
  import hrss_pkg::*;

  localparam int SID_W = $clog2(SERVER_COUNT);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  typedef struct packed {
    status_t              status;
    logic [SID_W-1:0]     server;
    logic [CNT_W-1:0]     count;
  } ring_reply_t;

  logic [POINT_W-1:0] ring_pos   [RING_DEPTH];
  logic [SID_W-1:0]   ring_owner [RING_DEPTH];
  int                 ring_size = 0;
  ring_reply_t        expected_replies[$];
  int                 errors_seen = 0;
  int                 checked_seen = 0;

  // Apply one word to the shadow ring and return the reply it should give.
  function automatic ring_reply_t ring_apply(op_t op, logic [POINT_W-1:0] point,
                                             logic [SID_W-1:0] sid,
                                             logic [POINT_W-1:0] hash,
                                             logic [SERVER_COUNT-1:0] mask);
    ring_reply_t r;
    int          slot;
    int          origin;
    int          found;
    int          idx;
    int          i;
    bit          skip;
    r.status = ST_OK;
    r.server = '0;
    case (op)
      OP_CLEAR: ring_size = 0;
      OP_INSERT: begin
        if (ring_size >= RING_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // place after every point at the same position
          slot = 0;
          while (slot < ring_size && ring_pos[slot] <= point) slot++;
          for (i = ring_size; i > slot; i--) begin
            ring_pos[i]   = ring_pos[i-1];
            ring_owner[i] = ring_owner[i-1];
          end
          ring_pos[slot]   = point;
          ring_owner[slot] = sid;
          ring_size++;
        end
      end
      default: begin
        if (ring_size == 0) begin
          r.status = ST_EMPTY;
        end else begin
          skip = (op == OP_LOOKUP_AFTER);
          if (!skip) begin
            origin = 0;
            while (origin < ring_size && ring_pos[origin] < hash) origin++;
            if (origin == ring_size) origin = 0;
          end else begin
            // an absent server leaves found at 0, so the walk starts at 1 modulo the size
            found = -1;
            for (i = 0; i < ring_size; i++)
              if (found < 0 && ring_owner[i] == sid) found = i;
            if (found < 0) found = 0;
            origin = (found + 1) % ring_size;
          end
          r.status = ST_NO_READY;
          for (i = 0; i < ring_size && r.status != ST_OK; i++) begin
            idx = (origin + i) % ring_size;
            if (!(skip && ring_owner[idx] == sid) && mask[ring_owner[idx]]) begin
              r.status = ST_OK;
              r.server = ring_owner[idx];
            end
          end
        end
      end
    endcase
    r.count = CNT_W'(ring_size);
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("checker: %s mismatch at %0t: got %0d, want %0d", field, $realtime, got,
             want);
    errors_seen++;
  endtask

  always @(posedge clk) begin
    ring_reply_t want;
    if (rst_n) begin
      // compare before taking a new word: a result and an accept can share an edge
      if (out_strobe) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected result, status", int'(out_status), -1);
        end else begin
          want = expected_replies.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", int'(out_status), int'(want.status));
          if (out_selected_server !== want.server)
            report_mismatch("selected_server", int'(out_selected_server),
                            int'(want.server));
          if (out_ring_count !== want.count)
            report_mismatch("ring_count", int'(out_ring_count), int'(want.count));
          checked_seen++;
        end
      end
      if (start && !busy)
        expected_replies.insert(expected_replies.size(),
                                ring_apply(op_t'(in_op), in_ring_point_value,
                                           in_server_id, in_key_hash,
                                           in_idle_mask));
    end
    mismatch_count  <= errors_seen;
    words_pending   <= expected_replies.size();
    results_checked <= checked_seen;
  end

endmodule

>>> tb/sv/hash_ring_server_select_core_tb.sv
// ----------------------------------------------------------------------------
// hash_ring_server_select_core_tb: testbench for the hash ring selector
// Drives directed corner words, then random runs of clears, insert bursts and
// lookups with random gaps, including one fill past capacity. A separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module hash_ring_server_select_core_tb;
  import hrss_pkg::*;

  localparam int RING_DEPTH   = 256;
  localparam int SERVER_COUNT = 16;
  localparam int SID_W        = $clog2(SERVER_COUNT);
  localparam int CNT_W        = $clog2(RING_DEPTH + 1);
  localparam int WORD_TARGET  = 1050;
  localparam int QUIET_FROM   = WORD_TARGET - 120;
  localparam int CYCLE_LIMIT  = 200000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              in_op = '0;
  logic [POINT_W-1:0]      in_ring_point_value = '0;
  logic [SID_W-1:0]        in_server_id = '0;
  logic [POINT_W-1:0]      in_key_hash = '0;
  logic [SERVER_COUNT-1:0] in_idle_mask = '0;
  logic                    out_strobe;
  logic [1:0]              out_status;
  logic [SID_W-1:0]        out_selected_server;
  logic [CNT_W-1:0]        out_ring_count;

  int mismatch_count;
  int words_pending;
  int results_checked;
  int cycle_count;

  // stimulus bookkeeping, not a prediction
  int                 words_sent = 0;
  int                 op_tally[4] = '{0, 0, 0, 0};
  int                 ring_fill = 0;
  int                 peak_fill = 0;
  int                 full_refusals = 0;
  logic [POINT_W-1:0] point_pool[$];
  logic [SID_W-1:0]   owner_pool[$];

  always #5 clk = ~clk;

  hash_ring_server_select_core #(
    .RING_DEPTH  (RING_DEPTH),
    .SERVER_COUNT(SERVER_COUNT)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_ring_point_value(in_ring_point_value),
    .in_server_id       (in_server_id),
    .in_key_hash        (in_key_hash),
    .in_idle_mask       (in_idle_mask),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_selected_server(out_selected_server),
    .out_ring_count     (out_ring_count)
  );

  hash_ring_server_select_checker #(
    .RING_DEPTH  (RING_DEPTH),
    .SERVER_COUNT(SERVER_COUNT)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_ring_point_value(in_ring_point_value),
    .in_server_id       (in_server_id),
    .in_key_hash        (in_key_hash),
    .in_idle_mask       (in_idle_mask),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_selected_server(out_selected_server),
    .out_ring_count     (out_ring_count),
    .mismatch_count     (mismatch_count),
    .words_pending      (words_pending),
    .results_checked    (results_checked)
  );

  // Present one word and hold it until the block takes it.
  task automatic issue_word(op_t op, logic [POINT_W-1:0] point, logic [SID_W-1:0] sid,
                            logic [POINT_W-1:0] hash, logic [SERVER_COUNT-1:0] mask);
    in_op               <= op;
    in_ring_point_value <= point;
    in_server_id        <= sid;
    in_key_hash         <= hash;
    in_idle_mask        <= mask;
    start               <= 1'b1;
    do @(posedge clk); while (busy);
    words_sent++;
    op_tally[op]++;
    if (op == OP_CLEAR) begin
      ring_fill = 0;
      point_pool.delete();
      owner_pool.delete();
    end else if (op == OP_INSERT) begin
      if (ring_fill >= RING_DEPTH) begin
        full_refusals++;
      end else begin
        ring_fill++;
        point_pool.insert(point_pool.size(), point);
        owner_pool.insert(owner_pool.size(), sid);
        if (ring_fill > peak_fill) peak_fill = ring_fill;
      end
    end
  endtask

  // Drop start and scramble the payload for a while.
  task automatic take_break(int cycles);
    start               <= 1'b0;
    in_op               <= 2'($urandom_range(0, 3));
    in_ring_point_value <= $urandom;
    in_server_id        <= SID_W'($urandom_range(0, SERVER_COUNT - 1));
    in_key_hash         <= $urandom;
    in_idle_mask        <= SERVER_COUNT'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_gap(bit gappy);
    if (gappy && $urandom_range(0, 2) == 0) take_break($urandom_range(1, 12));
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  function automatic logic [POINT_W-1:0] pick_point();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel >= 5 && point_pool.size() != 0) begin
      if (sel == 7) return point_pool[$urandom_range(0, point_pool.size() - 1)];
      return point_pool[$urandom_range(0, point_pool.size() - 1)] +
             $urandom_range(0, 6) - 3;
    end
    return $urandom;
  endfunction

  function automatic logic [POINT_W-1:0] pick_hash();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel >= 4 && point_pool.size() != 0)
      return point_pool[$urandom_range(0, point_pool.size() - 1)] +
             $urandom_range(0, 2) - 1;
    return $urandom;
  endfunction

  function automatic logic [SERVER_COUNT-1:0] pick_mask();
    case ($urandom_range(0, 6))
      0:       return '1;
      1:       return '0;
      2:       return SERVER_COUNT'(1) << $urandom_range(0, SERVER_COUNT - 1);
      3:       return ~(SERVER_COUNT'(1) << $urandom_range(0, SERVER_COUNT - 1));
      4:       return SERVER_COUNT'($urandom & $urandom & $urandom);
      default: return SERVER_COUNT'($urandom);
    endcase
  endfunction

  function automatic logic [SID_W-1:0] pick_owner();
    if (owner_pool.size() != 0 && $urandom_range(0, 3) != 0)
      return owner_pool[$urandom_range(0, owner_pool.size() - 1)];
    return SID_W'($urandom_range(0, SERVER_COUNT - 1));
  endfunction

  task automatic insert_burst(int n, bit gappy);
    repeat (n) begin
      maybe_gap(gappy);
      issue_word(OP_INSERT, pick_point(), SID_W'($urandom_range(0, SERVER_COUNT - 1)),
                 $urandom, SERVER_COUNT'($urandom));
    end
  endtask

  task automatic lookup_burst(int n, bit gappy);
    repeat (n) begin
      maybe_gap(gappy);
      if ($urandom_range(0, 1) == 0)
        issue_word(OP_LOOKUP_KEY, $urandom, SID_W'($urandom_range(0, SERVER_COUNT - 1)),
                   pick_hash(), pick_mask());
      else
        issue_word(OP_LOOKUP_AFTER, $urandom, pick_owner(), $urandom, pick_mask());
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycle_count,
             words_pending);
    $display("hash_ring_server_select_core_tb: done, errors");
    $finish;
  end

  initial begin
    bit gappy;
    bit filled = 1'b0;
    int choice;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty ring, then extremes, equal positions, wrap, skip and no-ready cases
    issue_word(OP_LOOKUP_KEY,   $urandom, 4'h3, $urandom,     16'hFFFF);
    issue_word(OP_LOOKUP_AFTER, $urandom, 4'h3, $urandom,     16'hFFFF);
    issue_word(OP_CLEAR,        $urandom, 4'h0, $urandom,     SERVER_COUNT'($urandom));
    issue_word(OP_INSERT,       32'h0000_0000, 4'h0, $urandom, SERVER_COUNT'($urandom));
    issue_word(OP_INSERT,       32'hFFFF_FFFF, 4'hF, $urandom, SERVER_COUNT'($urandom));
    issue_word(OP_INSERT,       32'h8000_0000, 4'h5, $urandom, SERVER_COUNT'($urandom));
    issue_word(OP_INSERT,       32'h8000_0000, 4'h9, $urandom, SERVER_COUNT'($urandom));
    issue_word(OP_LOOKUP_KEY,   $urandom, 4'h0, 32'h0000_0000, 16'hFFFF);
    issue_word(OP_LOOKUP_KEY,   $urandom, 4'h0, 32'hFFFF_FFFF, 16'h8000);
    issue_word(OP_LOOKUP_KEY,   $urandom, 4'h0, 32'h8000_0001, 16'h0200);
    issue_word(OP_LOOKUP_KEY,   $urandom, 4'h0, 32'h7FFF_FFFF, 16'h0000);
    issue_word(OP_LOOKUP_AFTER, $urandom, 4'h5, $urandom,     16'hFFFF);
    issue_word(OP_LOOKUP_AFTER, $urandom, 4'h3, $urandom,     16'hFFFF);
    issue_word(OP_LOOKUP_AFTER, $urandom, 4'hF, $urandom,     16'h8000);
    issue_word(OP_LOOKUP_AFTER, $urandom, 4'h0, $urandom,     16'h0001);
    issue_word(OP_CLEAR,        $urandom, 4'h0, $urandom,     SERVER_COUNT'($urandom));
    issue_word(OP_INSERT,       32'h1234_5678, 4'hA, $urandom, SERVER_COUNT'($urandom));
    issue_word(OP_LOOKUP_AFTER, $urandom, 4'hA, $urandom,     16'hFFFF);
    issue_word(OP_LOOKUP_KEY,   $urandom, 4'h0, 32'h0000_0001, 16'h0400);
    hold_until_drained();

    while (words_sent < WORD_TARGET) begin
      gappy  = (words_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      choice = $urandom_range(0, 19);
      if (!filled && words_sent >= 400) begin
        // fill to capacity, push past it, then look up on the full ring
        filled = 1'b1;
        while (ring_fill < RING_DEPTH) insert_burst(1, gappy);
        insert_burst(3, gappy);
        lookup_burst(12, gappy);
        hold_until_drained();
      end else if (choice == 0 || ring_fill > 64) begin
        maybe_gap(gappy);
        issue_word(OP_CLEAR, $urandom, SID_W'($urandom_range(0, SERVER_COUNT - 1)),
                   $urandom, SERVER_COUNT'($urandom));
      end else if (choice <= 7) begin
        insert_burst($urandom_range(1, 8), gappy);
      end else if (choice <= 17) begin
        lookup_burst($urandom_range(1, 8), gappy);
      end else if (choice == 18) begin
        repeat ($urandom_range(1, 4)) begin
          maybe_gap(gappy);
          issue_word(op_t'($urandom_range(0, 3)), $urandom,
                     SID_W'($urandom_range(0, SERVER_COUNT - 1)), $urandom,
                     SERVER_COUNT'($urandom));
        end
      end else if (words_sent < QUIET_FROM) begin
        hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (12) @(posedge clk);
    $display("covered %0d words: %0d clear, %0d insert, %0d key lookup, %0d after lookup",
             words_sent, op_tally[OP_CLEAR], op_tally[OP_INSERT],
             op_tally[OP_LOOKUP_KEY], op_tally[OP_LOOKUP_AFTER]);
    $display("ring peaked at %0d points, %0d inserts refused when full, %0d results checked",
             peak_fill, full_refusals, results_checked);
    if (mismatch_count == 0) begin
      $display("hash_ring_server_select_core_tb: done, clean");
    end else begin
      $display("hash_ring_server_select_core_tb: done, errors");
    end
    $finish;
  end

endmodule
